// ----- hdl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Spectrum bin smoother package
// Shared constants, register codes and payload types of the smoother.
// ----------------------------------------------------------------------------
package sbs_pkg;

    // Number of bins held in the store and the width of a bin number.
    localparam int MAX_BINS  = 1024;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = BIN_W + 1;

    // The magnitude divisor of 2048 is a right shift.
    localparam int MAG_SHIFT = 11;
    localparam int MAG_W     = 32 - MAG_SHIFT;
    localparam int K_W       = 17;
    localparam int PRE_W     = K_W + MAG_W;

    // 20*log10(2) in Q16.
    localparam logic signed [19:0] DB_PER_LOG2 = 20'sd394566;

    // Register reset values.
    localparam logic [K_W-1:0]    SMOOTHING_RESET = 17'd52429;
    localparam logic [15:0]       MIN_DB_RESET    = 16'h9C00;
    localparam logic [15:0]       MAX_DB_RESET    = 16'hE200;
    localparam logic [CNT_W-1:0]  BINS_RESET      = CNT_W'(MAX_BINS);

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_SMOOTHING = 2'd0,
        CFG_MIN_DB    = 2'd1,
        CFG_MAX_DB    = 2'd2,
        CFG_BINS      = 2'd3
    } t_cfg_idx;

    // One input request.
    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [BIN_W-1:0]   out_bin;
        logic [31:0]        smoothed_magnitude;
        logic signed [15:0] level_db;
        logic [7:0]         level_byte;
        logic               index_error;
    } t_out_item;

    // Sideband that travels through the square root pipeline.
    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic             err;
    } t_sq_side;

    // Sideband that travels through the decibel pipeline.
    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic             err;
        logic [31:0]      sm;
    } t_db_side;

    // Sideband of the byte scaling divider.
    typedef struct packed {
        logic [BIN_W-1:0]   idx;
        logic               err;
        logic [31:0]        sm;
        logic signed [15:0] db;
        logic               pos;
        logic               sat;
        logic [15:0]        den;
    } t_dv_side;

endpackage

// ----- hdl/sbs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sbs_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module sbs_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sbs_pkg::t_sq_side  i_side,
    input  logic [63:0]        i_value,
    output logic               o_valid,
    output sbs_pkg::t_sq_side  o_side,
    output logic [31:0]        o_root
);

    logic              r_vld  [0:32];
    sbs_pkg::t_sq_side r_side [0:32];
    logic [63:0]       r_v    [0:32];
    logic [63:0]       r_res  [0:32];
    logic [63:0]       n_v    [0:32];
    logic [63:0]       n_res  [0:32];
    logic [63:0]       w_try  [0:31];

    // Each stage tries one root bit against the remaining value.
    always_comb begin
        n_v[0]   = i_value;
        n_res[0] = '0;
        for (int j = 0; j < 32; j++) begin
            w_try[j] = r_res[j] + (64'd1 << (2 * (31 - j)));
            if (r_v[j] >= w_try[j]) begin
                n_v[j+1]   = r_v[j] - w_try[j];
                n_res[j+1] = (r_res[j] >> 1) + (64'd1 << (2 * (31 - j)));
            end else begin
                n_v[j+1]   = r_v[j];
                n_res[j+1] = r_res[j] >> 1;
            end
        end
    end

    // Stage registers; valid bits are cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= 32; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int j = 0; j < 32; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 0; j <= 32; j++) begin
                r_v[j]   <= n_v[j];
                r_res[j] <= n_res[j];
            end
            for (int j = 0; j < 32; j++) begin
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_vld[32];
    assign o_side  = r_side[32];
    assign o_root  = r_res[32][31:0];

endmodule

// ----- hdl/sbs_db.sv -----
// ----------------------------------------------------------------------------
// Decibel conversion pipeline
// Q3.29 magnitude to Q8.8 decibels through a sixteen stage log2 by squaring.
// ----------------------------------------------------------------------------
module sbs_db (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sbs_pkg::t_db_side  i_side,
    input  logic signed [15:0] i_min_db,
    output logic               o_valid,
    output sbs_pkg::t_db_side  o_side,
    output logic signed [15:0] o_db
);

    // First normalising stage: shifts by sixteen and eight.
    logic              r_n1_vld;
    sbs_pkg::t_db_side r_n1_side;
    logic [31:0]       r_n1_x;
    logic [4:0]        r_n1_s;
    logic              r_n1_zero;
    logic [31:0]       w_n1_a;
    logic [31:0]       w_n1_b;
    logic [4:0]        w_n1_s;

    always_comb begin
        w_n1_s = '0;
        w_n1_a = i_side.sm;
        if (i_side.sm[31:16] == 16'd0) begin
            w_n1_a = i_side.sm << 16;
            w_n1_s = 5'd16;
        end
        w_n1_b = w_n1_a;
        if (w_n1_a[31:24] == 8'd0) begin
            w_n1_b = w_n1_a << 8;
            w_n1_s = w_n1_s + 5'd8;
        end
    end

    // Second normalising stage: shifts by four, two and one.
    logic [31:0] w_n2_a;
    logic [31:0] w_n2_b;
    logic [31:0] w_n2_c;
    logic [4:0]  w_n2_s;

    always_comb begin
        w_n2_s = r_n1_s;
        w_n2_a = r_n1_x;
        if (r_n1_x[31:28] == 4'd0) begin
            w_n2_a = r_n1_x << 4;
            w_n2_s = w_n2_s + 5'd4;
        end
        w_n2_b = w_n2_a;
        if (w_n2_a[31:30] == 2'd0) begin
            w_n2_b = w_n2_a << 2;
            w_n2_s = w_n2_s + 5'd2;
        end
        w_n2_c = w_n2_b;
        if (!w_n2_b[31]) begin
            w_n2_c = w_n2_b << 1;
            w_n2_s = w_n2_s + 5'd1;
        end
    end

    // Squaring stages; stage zero holds the normalised mantissa.
    logic              r_sq_vld  [0:16];
    sbs_pkg::t_db_side r_sq_side [0:16];
    logic [31:0]       r_sq_x    [0:16];
    logic [15:0]       r_sq_f    [0:16];
    logic [4:0]        r_sq_e    [0:16];
    logic              r_sq_zero [0:16];
    logic [63:0]       w_sq_y    [0:15];
    logic [31:0]       n_sq_x    [1:16];
    logic [15:0]       n_sq_f    [1:16];

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_sq_y[j] = 64'(r_sq_x[j]) * 64'(r_sq_x[j]);
            if (w_sq_y[j][63]) begin
                n_sq_x[j+1] = w_sq_y[j][63:32];
                n_sq_f[j+1] = r_sq_f[j] | (16'd1 << (15 - j));
            end else begin
                n_sq_x[j+1] = w_sq_y[j][62:31];
                n_sq_f[j+1] = r_sq_f[j];
            end
        end
    end

    // Scale the Q16 log2 into decibels.
    logic [6:0]         w_e_m29;
    logic signed [22:0] w_lg;
    logic signed [42:0] w_prod;

    assign w_e_m29 = {2'b00, r_sq_e[16]} - 7'd29;
    assign w_lg    = $signed({w_e_m29, r_sq_f[16]});
    assign w_prod  = w_lg * sbs_pkg::DB_PER_LOG2;

    logic               r_pr_vld;
    sbs_pkg::t_db_side  r_pr_side;
    logic signed [42:0] r_pr_prod;
    logic               r_pr_zero;

    // Round half away from zero, then saturate.
    logic [42:0]        w_abs;
    logic [42:0]        w_rnd;
    logic [18:0]        w_qmag;
    logic signed [15:0] w_sat;

    always_comb begin
        w_abs  = r_pr_prod[42] ? 43'(-r_pr_prod) : 43'(r_pr_prod);
        w_rnd  = w_abs + 43'd8388608;
        w_qmag = w_rnd[42:24];
        if (r_pr_prod[42]) begin
            if (w_qmag > 19'd32768) begin
                w_sat = 16'sh8000;
            end else begin
                w_sat = 16'(-$signed({1'b0, w_qmag}));
            end
        end else begin
            if (w_qmag > 19'd32767) begin
                w_sat = 16'sh7FFF;
            end else begin
                w_sat = $signed(w_qmag[15:0]);
            end
        end
    end

    logic               r_o_vld;
    sbs_pkg::t_db_side  r_o_side;
    logic signed [15:0] r_o_db;

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_vld <= 1'b0;
            r_pr_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            for (int j = 0; j <= 16; j++) begin
                r_sq_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_n1_vld    <= i_valid;
            r_sq_vld[0] <= r_n1_vld;
            for (int j = 0; j < 16; j++) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
            r_pr_vld <= r_sq_vld[16];
            r_o_vld  <= r_pr_vld;
        end
    end

    // Payload of every stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1_side <= i_side;
            r_n1_x    <= w_n1_b;
            r_n1_s    <= w_n1_s;
            r_n1_zero <= (i_side.sm == 32'd0);

            r_sq_side[0] <= r_n1_side;
            r_sq_x[0]    <= w_n2_c;
            r_sq_f[0]    <= '0;
            r_sq_e[0]    <= 5'd31 - w_n2_s;
            r_sq_zero[0] <= r_n1_zero;
            for (int j = 0; j < 16; j++) begin
                r_sq_side[j+1] <= r_sq_side[j];
                r_sq_x[j+1]    <= n_sq_x[j+1];
                r_sq_f[j+1]    <= n_sq_f[j+1];
                r_sq_e[j+1]    <= r_sq_e[j];
                r_sq_zero[j+1] <= r_sq_zero[j];
            end

            r_pr_side <= r_sq_side[16];
            r_pr_prod <= w_prod;
            r_pr_zero <= r_sq_zero[16];

            r_o_side <= r_pr_side;
            r_o_db   <= r_pr_zero ? i_min_db : w_sat;
        end
    end

    assign o_valid = r_o_vld;
    assign o_side  = r_o_side;
    assign o_db    = r_o_db;

endmodule

// ----- hdl/spectrum_bin_smoother_db_top.sv -----
// ----------------------------------------------------------------------------
// Spectrum bin smoother with decibel readout
// FFT bin magnitude, per-bin exponential smoothing, dB level and byte level.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the input is not stalled, also for
// repeats of the same bin, as the smoothed value is forwarded to the blend stage.
// Reset: after reset a clearing pass zeroes the 1024-entry store, one entry a
// cycle; requests are stalled until the pass ends, configuration is taken.
// ----------------------------------------------------------------------------
module spectrum_bin_smoother_db_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sbs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sbs_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int BW = sbs_pkg::BIN_W;

    // Configuration registers.
    logic [sbs_pkg::K_W-1:0]   r_smoothing;
    logic signed [15:0]        r_min_db;
    logic signed [15:0]        r_max_db;
    logic [sbs_pkg::CNT_W-1:0] r_bins;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing <= sbs_pkg::SMOOTHING_RESET;
            r_min_db    <= $signed(sbs_pkg::MIN_DB_RESET);
            r_max_db    <= $signed(sbs_pkg::MAX_DB_RESET);
            r_bins      <= sbs_pkg::BINS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbs_pkg::CFG_SMOOTHING: r_smoothing <= i_cfg_data;
                sbs_pkg::CFG_MIN_DB:    r_min_db    <= $signed(i_cfg_data[15:0]);
                sbs_pkg::CFG_MAX_DB:    r_max_db    <= $signed(i_cfg_data[15:0]);
                sbs_pkg::CFG_BINS:      r_bins      <= i_cfg_data[sbs_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves while the output register can take a result.
    logic r_out_vld;
    logic w_en;
    logic r_clearing;
    logic [BW-1:0] r_clr_cnt;

    assign w_en       = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_clearing || !w_en;

    // Clearing pass over the store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == BW'(sbs_pkg::MAX_BINS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Input stage: range check and Nyquist slot handling.
    logic               r_s0_vld;
    logic [BW-1:0]      r_s0_idx;
    logic               r_s0_err;
    logic signed [31:0] r_s0_re;
    logic signed [31:0] r_s0_im;

    // Squares, then their sum.
    logic               r_s1_vld;
    sbs_pkg::t_sq_side  r_s1_side;
    logic [63:0]        r_s1_sq_re;
    logic [63:0]        r_s1_sq_im;
    logic signed [63:0] w_sq_re;
    logic signed [63:0] w_sq_im;

    logic               r_s2_vld;
    sbs_pkg::t_sq_side  r_s2_side;
    logic [63:0]        r_s2_sum;

    assign w_sq_re = r_s0_re * r_s0_re;
    assign w_sq_im = r_s0_im * r_s0_im;

    logic              q_vld;
    sbs_pkg::t_sq_side q_side;
    logic [31:0]       q_root;

    sbs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_side  (r_s2_side),
        .i_value (r_s2_sum),
        .o_valid (q_vld),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    // Weights of the blend, with k limited to one.
    logic [sbs_pkg::K_W-1:0]   w_k;
    logic [sbs_pkg::K_W-1:0]   w_k_inv;
    logic [sbs_pkg::MAG_W-1:0] w_mag;
    logic [sbs_pkg::PRE_W-1:0] w_pre;

    assign w_k     = (r_smoothing > 17'd65536) ? 17'd65536 : r_smoothing;
    assign w_k_inv = 17'd65536 - w_k;
    assign w_mag   = q_root[31:sbs_pkg::MAG_SHIFT];
    assign w_pre   = sbs_pkg::PRE_W'(w_k_inv) * sbs_pkg::PRE_W'(w_mag)
                   + sbs_pkg::PRE_W'(32768);

    // Read stage and blend stage of the store.
    logic                      r_s3_vld;
    logic [BW-1:0]             r_s3_idx;
    logic                      r_s3_err;
    logic [sbs_pkg::PRE_W-1:0] r_s3_pre;

    logic                      r_s4_vld;
    logic [BW-1:0]             r_s4_idx;
    logic                      r_s4_err;
    logic [sbs_pkg::PRE_W-1:0] r_s4_pre;

    logic                      r_s5_vld;
    logic [BW-1:0]             r_s5_idx;
    logic                      r_s5_err;
    logic [31:0]               r_s5_sm;

    logic                      r_last_vld;
    logic [BW-1:0]             r_last_idx;
    logic [31:0]               r_last_sm;

    logic          w_ram_we;
    logic [BW-1:0] w_ram_waddr;
    logic [31:0]   w_ram_wdata;
    logic [31:0]   w_ram_rdata;

    assign w_ram_we    = r_clearing || (w_en && r_s5_vld && !r_s5_err);
    assign w_ram_waddr = r_clearing ? r_clr_cnt : r_s5_idx;
    assign w_ram_wdata = r_clearing ? 32'd0 : r_s5_sm;

    sbs_ram #(
        .WIDTH (32),
        .DEPTH (sbs_pkg::MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_en),
        .i_raddr (r_s3_idx),
        .o_rdata (w_ram_rdata)
    );

    // The previous value comes from the newest write still in flight.
    logic [31:0] w_old;
    logic [48:0] w_mix;

    always_comb begin
        if (r_s5_vld && !r_s5_err && (r_s5_idx == r_s4_idx)) begin
            w_old = r_s5_sm;
        end else if (r_last_vld && (r_last_idx == r_s4_idx)) begin
            w_old = r_last_sm;
        end else begin
            w_old = w_ram_rdata;
        end
        w_mix = 49'(w_k) * 49'(w_old) + 49'(r_s4_pre);
    end

    logic               d_vld;
    sbs_pkg::t_db_side  d_side;
    logic signed [15:0] d_db;

    sbs_db u_db (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s5_vld),
        .i_side   ({r_s5_idx, r_s5_err, r_s5_sm}),
        .i_min_db (r_min_db),
        .o_valid  (d_vld),
        .o_side   (d_side),
        .o_db     (d_db)
    );

    // Byte scaling set-up: signed numerator and positive divisor.
    logic signed [16:0] w_diff;
    logic signed [25:0] w_num;
    logic signed [16:0] w_den;
    logic signed [25:0] w_num_p;
    logic signed [16:0] w_den_p;

    always_comb begin
        w_diff = 17'(d_db) - 17'(r_min_db);
        w_num  = 26'(w_diff) * 26'sd255;
        w_den  = (r_max_db == r_min_db) ? 17'sd256 : 17'(r_max_db) - 17'(r_min_db);
        if (w_den < 0) begin
            w_num_p = -w_num;
            w_den_p = -w_den;
        end else begin
            w_num_p = w_num;
            w_den_p = w_den;
        end
    end

    logic              r_b0_vld;
    sbs_pkg::t_dv_side r_b0_side;
    logic [23:0]       r_b0_num;

    // Divider stages, one quotient bit each.
    logic              r_dv_vld  [0:8];
    sbs_pkg::t_dv_side r_dv_side [0:8];
    logic [23:0]       r_dv_rem  [0:8];
    logic [7:0]        r_dv_q    [0:8];
    logic [23:0]       w_dv_sub  [0:7];
    logic [23:0]       n_dv_rem  [1:8];
    logic [7:0]        n_dv_q    [1:8];
    sbs_pkg::t_dv_side w_b1_side;

    always_comb begin
        w_b1_side     = r_b0_side;
        w_b1_side.sat = (r_b0_num >= {r_b0_side.den, 8'd0});
        for (int j = 0; j < 8; j++) begin
            w_dv_sub[j] = 24'(r_dv_side[j].den) << (7 - j);
            if (r_dv_rem[j] >= w_dv_sub[j]) begin
                n_dv_rem[j+1] = r_dv_rem[j] - w_dv_sub[j];
                n_dv_q[j+1]   = r_dv_q[j] | (8'd1 << (7 - j));
            end else begin
                n_dv_rem[j+1] = r_dv_rem[j];
                n_dv_q[j+1]   = r_dv_q[j];
            end
        end
    end

    sbs_pkg::t_out_item r_out;
    sbs_pkg::t_out_item w_out;

    // Result assembly; a rejected bin reports zeros.
    always_comb begin
        w_out.out_bin            = r_dv_side[8].idx;
        w_out.index_error        = r_dv_side[8].err;
        w_out.smoothed_magnitude = r_dv_side[8].err ? 32'd0 : r_dv_side[8].sm;
        w_out.level_db           = r_dv_side[8].err ? 16'sd0 : r_dv_side[8].db;
        if (r_dv_side[8].err || !r_dv_side[8].pos) begin
            w_out.level_byte = 8'd0;
        end else if (r_dv_side[8].sat) begin
            w_out.level_byte = 8'd255;
        end else begin
            w_out.level_byte = r_dv_q[8];
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_s5_vld   <= 1'b0;
            r_last_vld <= 1'b0;
            r_b0_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int j = 0; j <= 8; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_s0_vld   <= i_in_valid && !r_clearing;
            r_s1_vld   <= r_s0_vld;
            r_s2_vld   <= r_s1_vld;
            r_s3_vld   <= q_vld;
            r_s4_vld   <= r_s3_vld;
            r_s5_vld   <= r_s4_vld;
            r_last_vld <= r_s5_vld && !r_s5_err;
            r_b0_vld   <= d_vld;
            r_dv_vld[0] <= r_b0_vld;
            for (int j = 0; j < 8; j++) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            r_out_vld <= r_dv_vld[8];
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_idx <= i_in_item.bin_index;
            r_s0_err <= ({1'b0, i_in_item.bin_index} >= r_bins);
            r_s0_re  <= i_in_item.real_part;
            r_s0_im  <= (i_in_item.bin_index == '0) ? 32'sd0 : i_in_item.imag_part;

            r_s1_side  <= '{idx: r_s0_idx, err: r_s0_err};
            r_s1_sq_re <= $unsigned(w_sq_re);
            r_s1_sq_im <= $unsigned(w_sq_im);

            r_s2_side <= r_s1_side;
            r_s2_sum  <= r_s1_sq_re + r_s1_sq_im;

            r_s3_idx <= q_side.idx;
            r_s3_err <= q_side.err;
            r_s3_pre <= w_pre;

            r_s4_idx <= r_s3_idx;
            r_s4_err <= r_s3_err;
            r_s4_pre <= r_s3_pre;

            r_s5_idx <= r_s4_idx;
            r_s5_err <= r_s4_err;
            r_s5_sm  <= w_mix[47:16];

            r_last_idx <= r_s5_idx;
            r_last_sm  <= r_s5_sm;

            r_b0_side.idx <= d_side.idx;
            r_b0_side.err <= d_side.err;
            r_b0_side.sm  <= d_side.sm;
            r_b0_side.db  <= d_db;
            r_b0_side.pos <= (w_num_p > 0);
            r_b0_side.sat <= 1'b0;
            r_b0_side.den <= w_den_p[15:0];
            r_b0_num      <= w_num_p[23:0];

            r_dv_side[0] <= w_b1_side;
            r_dv_rem[0]  <= r_b0_num;
            r_dv_q[0]    <= '0;
            for (int j = 0; j < 8; j++) begin
                r_dv_side[j+1] <= r_dv_side[j];
                r_dv_rem[j+1]  <= n_dv_rem[j+1];
                r_dv_q[j+1]    <= n_dv_q[j+1];
            end

            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ----- hdl/sbs_checker.sv -----
// ----------------------------------------------------------------------------
// Spectrum bin smoother port checker
// Watches the top level ports over time and reports broken behaviour.
// ----------------------------------------------------------------------------
module sbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sbs_pkg::t_out_item o_out_item
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    // A rejected bin reports zero levels and magnitude.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.index_error |->
            o_out_item.smoothed_magnitude == 32'd0 &&
            o_out_item.level_db == 16'sd0 && o_out_item.level_byte == 8'd0)
        else $error("rejected bin carries nonzero result fields");

    // Requests are held off straight after reset, when the clearing of the store begins.
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request port open straight after reset");

endmodule

bind spectrum_bin_smoother_db_top sbs_checker u_sbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- verif/tb_spectrum_bin_smoother_db_top.sv -----
// ----------------------------------------------------------------------------
// Spectrum bin smoother testbench
// Drives FFT bin requests with random gaps and output stalls through several
// register settings, predicts each smoothed magnitude, dB level and byte
// level with an independent model of the block and compares every result.
// ----------------------------------------------------------------------------
module tb_spectrum_bin_smoother_db_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sbs_pkg::*;

    // Scoreboard: holds the bin store copy, the register copy and the queue of
    // predicted results.
    class bin_level_board;
        logic [31:0]  mag_store [MAX_BINS];
        logic [16:0]  k_reg;
        logic [15:0]  lo_reg;
        logic [15:0]  hi_reg;
        logic [10:0]  bins_reg;
        t_out_item    pending_levels[$];
        int           mismatches;

        function void clear();
            foreach (mag_store[i]) mag_store[i] = '0;
            k_reg = SMOOTHING_RESET;
            lo_reg = MIN_DB_RESET;
            hi_reg = MAX_DB_RESET;
            bins_reg = BINS_RESET;
            pending_levels.delete();
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [16:0] val);
            case (idx)
                CFG_SMOOTHING: k_reg = val;
                CFG_MIN_DB:    lo_reg = val[15:0];
                CFG_MAX_DB:    hi_reg = val[15:0];
                default:       bins_reg = val[10:0];
            endcase
        endfunction

        // Integer square root by bit pairs.
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Q8.8 dB level of a nonzero Q3.29 magnitude, by repeated squaring.
        function logic signed [15:0] mag_to_db(logic [31:0] m);
            int            msb;
            longint unsigned x;
            longint        frac, lg, prod, q;
            msb = 31;
            while (msb > 0 && !m[msb]) msb--;
            x = (64'(m) << (31 - msb)) & 64'hFFFF_FFFF;
            frac = 0;
            for (int i = 15; i >= 0; i--) begin
                x = (x * x) >> 31;
                if (x >= (64'd1 << 32)) begin
                    frac |= 64'sd1 << i;
                    x >>= 1;
                end
            end
            lg = longint'(msb - 29) * 65536 + frac;
            prod = lg * 394566;
            if (prod < 0) q = -((-prod + (64'sd1 << 23)) >>> 24);
            else          q = (prod + (64'sd1 << 23)) >>> 24;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[15:0];
        endfunction

        function void note_request(t_in_item it);
            t_out_item       r;
            longint          re, im, lo, hi, db, num, den, sc;
            longint unsigned mag, kk, mix;
            r = '0;
            r.out_bin = it.bin_index;
            if (it.bin_index >= bins_reg) begin
                r.index_error = 1'b1;
                pending_levels.push_back(r);
                return;
            end
            re = longint'(it.real_part);
            im = (it.bin_index == 0) ? 0 : longint'(it.imag_part);
            mag = root_floor(longint'(re * re) + longint'(im * im)) / 2048;
            kk = (k_reg > 65536) ? 65536 : k_reg;
            mix = (kk * mag_store[it.bin_index] + (65536 - kk) * mag + 32768) >> 16;
            mag_store[it.bin_index] = mix[31:0];
            r.smoothed_magnitude = mix[31:0];
            lo = longint'($signed(lo_reg));
            hi = longint'($signed(hi_reg));
            db = (mix[31:0] == 0) ? lo : longint'(mag_to_db(mix[31:0]));
            num = 255 * (db - lo);
            den = (hi == lo) ? 256 : hi - lo;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            if (num <= 0) sc = 0;
            else begin
                sc = num / den;
                if (sc > 255) sc = 255;
            end
            r.level_db = db[15:0];
            r.level_byte = sc[7:0];
            pending_levels.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                mismatches++;
                return;
            end
            exp_r = pending_levels.pop_front();
            if (got.out_bin !== exp_r.out_bin) begin
                $display("%0t: out_bin expected %0d actual %0d", $realtime,
                         exp_r.out_bin, got.out_bin);
                mismatches++;
            end
            if (got.smoothed_magnitude !== exp_r.smoothed_magnitude) begin
                $display("%0t: smoothed_magnitude expected %0d actual %0d", $realtime,
                         exp_r.smoothed_magnitude, got.smoothed_magnitude);
                mismatches++;
            end
            if (got.level_db !== exp_r.level_db) begin
                $display("%0t: level_db expected %0d actual %0d", $realtime,
                         exp_r.level_db, got.level_db);
                mismatches++;
            end
            if (got.level_byte !== exp_r.level_byte) begin
                $display("%0t: level_byte expected %0d actual %0d", $realtime,
                         exp_r.level_byte, got.level_byte);
                mismatches++;
            end
            if (got.index_error !== exp_r.index_error) begin
                $display("%0t: index_error expected %0d actual %0d", $realtime,
                         exp_r.index_error, got.index_error);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    bin_level_board board;
    int unsigned    cycle_count;
    bit             stall_quiet;

    spectrum_bin_smoother_db_top u_dut (.*);

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: random stall per result, and every accepted result checked.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall && i_rst_n) board.check_result(o_out_item);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                hold = stall_quiet ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0) hold = 0;
                i_out_stall <= (hold > 0);
                if (hold > 0) hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Send one bin request, after a random gap unless no_gap is set; valid stays
    // high after the request is taken, so back-to-back requests follow without a gap.
    task automatic send_bin(t_in_item it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(it);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_levels.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_item make_bin(logic [9:0] idx, logic [31:0] re, logic [31:0] im);
        t_in_item it;
        it.bin_index = idx;
        it.real_part = re;
        it.imag_part = im;
        return it;
    endfunction

    // Random bin: mostly in range, varied magnitudes from tiny to full scale.
    function automatic t_in_item rand_bin(int lim);
        t_in_item    it;
        int          sh;
        it.bin_index = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, lim - 1));
        sh = $urandom_range(0, 31);
        it.real_part = $signed($urandom()) >>> sh;
        sh = $urandom_range(0, 31);
        it.imag_part = $signed($urandom()) >>> sh;
        return it;
    endfunction

    initial begin
        board = new();
        board.clear();
        cycle_count = 0;
        stall_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SMOOTHING;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, bin 0 with a Nyquist term, zero input,
        // repeats of one bin, and out-of-range indexes.
        send_bin(make_bin(10'd0, 32'h8000_0000, 32'h7FFF_FFFF), 0);
        send_bin(make_bin(10'd0, 32'h7FFF_FFFF, 32'h8000_0000), 0);
        send_bin(make_bin(10'd1, 32'h8000_0000, 32'h8000_0000), 1);
        send_bin(make_bin(10'd1, 32'h8000_0000, 32'h8000_0000), 1);
        send_bin(make_bin(10'd2, 32'h0, 32'h0), 0);
        send_bin(make_bin(10'd3, 32'h0000_0800, 32'h0), 1);
        send_bin(make_bin(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
        send_bin(make_bin(10'd1023, 32'hFFFF_FFFF, 32'h0000_0001), 1);
        send_bin(make_bin(10'd512, 32'h1234_5678, 32'hEDCB_A987), 0);
        drain();
        write_cfg(CFG_BINS, 17'd16);
        send_bin(make_bin(10'd16, 32'h4000_0000, 32'h0), 0);
        send_bin(make_bin(10'd15, 32'h4000_0000, 32'h0), 1);
        send_bin(make_bin(10'd1023, 32'h4000_0000, 32'h0), 1);
        drain();
        write_cfg(CFG_BINS, 17'd0);
        send_bin(make_bin(10'd0, 32'h1, 32'h1), 0);
        drain();

        // Random phases across register settings, extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            int lim;
            case (ph)
                0: begin
                    write_cfg(CFG_SMOOTHING, 17'd0);
                    write_cfg(CFG_MIN_DB, 17'h08000);
                    write_cfg(CFG_MAX_DB, 17'h07FFF);
                end
                1: begin
                    write_cfg(CFG_SMOOTHING, 17'h1FFFF);
                    write_cfg(CFG_MIN_DB, 17'h07FFF);
                    write_cfg(CFG_MAX_DB, 17'h08000);
                end
                2: begin
                    write_cfg(CFG_SMOOTHING, 17'd65536);
                    write_cfg(CFG_MIN_DB, 17'h0EC00);
                    write_cfg(CFG_MAX_DB, 17'h0EC00);
                end
                3: begin
                    write_cfg(CFG_SMOOTHING, 17'd52429);
                    write_cfg(CFG_MIN_DB, 17'h09C00);
                    write_cfg(CFG_MAX_DB, 17'h0E200);
                end
                default: begin
                    write_cfg(CFG_SMOOTHING, 17'($urandom_range(0, 131071)));
                    write_cfg(CFG_MIN_DB, 17'($urandom_range(0, 65535)));
                    write_cfg(CFG_MAX_DB, 17'($urandom_range(0, 65535)));
                end
            endcase
            lim = (ph == 3) ? 1024 : $urandom_range(16, 1024);
            if (ph == 5) lim = 2047;
            write_cfg(CFG_BINS, 17'(lim));
            if (lim > 1024) lim = 1024;
            stall_quiet = (ph == 6);
            for (int n = 0; n < 210; n++) begin
                t_in_item it;
                it = rand_bin(($urandom_range(0, 1) == 0) ? 16 : lim);
                send_bin(it, (ph == 6) || ($urandom_range(0, 3) == 0));
                // Sender holds off until the pipeline has emptied.
                if (n == 100) begin
                    i_in_valid <= 1'b0;
                    while (board.pending_levels.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending_levels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- spectrum_bin_smoother_db_top.f -----
hdl/sbs_pkg.sv
hdl/sbs_ram.sv
hdl/sbs_isqrt.sv
hdl/sbs_db.sv
hdl/spectrum_bin_smoother_db_top.sv
hdl/sbs_checker.sv
verif/tb_spectrum_bin_smoother_db_top.sv
